### hw/rtl/pdenc_pkg.sv
`default_nettype none

package pdenc_pkg;

    localparam int PIXEL_W      = 16;
    localparam int MAPPED_W     = PIXEL_W + 1;
    localparam int BYTE_W       = 8;
    localparam int BUF_DEPTH    = 32;
    localparam int BUF_AW       = $clog2(BUF_DEPTH);
    localparam int COUNT_W      = BUF_AW + 1;
    localparam int PAIR_IDX_W   = 3;
    localparam int SUM_W        = 9;
    localparam int PROD_W       = 2 * SUM_W;
    localparam int CODE_W       = 17;

    localparam logic [MAPPED_W-1:0] DIFF_LIMIT      = MAPPED_W'(129);
    localparam logic [CODE_W-1:0]   ONE_BYTE_LIMIT  = CODE_W'(224);
    localparam logic [CODE_W-1:0]   TWO_BYTE_LIMIT  = CODE_W'(8416);
    localparam logic [15:0]         TWO_BYTE_OFFSET = 16'd57120;
    localparam logic [BYTE_W-1:0]   FIRST_FLAG_BIT  = 8'd128;
    localparam logic [PAIR_IDX_W-1:0] LAST_PAIR     = PAIR_IDX_W'(7);

    localparam logic [1:0] PUSH_ONE  = 2'd0;
    localparam logic [1:0] PUSH_TWO  = 2'd1;
    localparam logic [1:0] PUSH_FOUR = 2'd3;

    typedef struct packed {
        logic accept;
        logic mult;
        logic code;
        logic push;
        logic emit_flag;
        logic emit_byte;
    } pdenc_cmd_t;

    typedef struct packed {
        logic pair_done;
        logic push_final;
        logic group_full;
        logic out_free;
        logic group_empty;
        logic drain_final;
    } pdenc_status_t;

endpackage

`default_nettype wire

### hw/rtl/pdenc_if.sv
`default_nettype none

interface pdenc_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel;
    logic               row_start;

    modport source (output valid, output pixel, output row_start, input ready);
    modport sink (input valid, input pixel, input row_start, output ready);
endinterface

interface pdenc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/pdenc_ctrl.sv
`default_nettype none

module pdenc_ctrl
    import pdenc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pdenc_status_t status,
    output pdenc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_CODE,
        S_PUSH,
        S_FLAG,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid && ready_reg;
                if (cmd.accept && status.pair_done)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_CODE;
            end
            S_CODE:
            begin
                cmd.code   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (status.push_final)
                begin
                    state_next = status.group_full ? S_FLAG : S_IDLE;
                end
            end
            S_FLAG:
            begin
                if (status.out_free)
                begin
                    cmd.emit_flag = 1'b1;
                    state_next    = status.group_empty ? S_IDLE : S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (status.drain_final)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

### hw/rtl/pdenc_dp.sv
`default_nettype none

module pdenc_dp
    import pdenc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pdenc_cmd_t                 cmd,
    output pdenc_status_t                   status,
    input  wire logic signed [PIXEL_W-1:0]  pixel,
    input  wire logic                       row_start,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [BYTE_W-1:0]               out_byte,
    output logic                            last_of_run
);

    logic [PIXEL_W-1:0]    prev_reg;
    logic [PIXEL_W-1:0]    first_pix_reg;
    logic [MAPPED_W-1:0]   m1_reg;
    logic                  second_reg;
    logic [PAIR_IDX_W-1:0] pair_idx_reg;
    logic [BYTE_W-1:0]     flag_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [BUF_AW-1:0]     rd_idx_reg;
    logic                  out_valid_reg;
    logic [1:0]            push_left_reg;

    logic [PIXEL_W-1:0]    pix2_reg;
    logic [MAPPED_W-1:0]   m2_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  big_reg;
    logic [31:0]           push_bytes_reg;
    logic [BYTE_W-1:0]     rd_data_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  last_reg;

    logic [BYTE_W-1:0]     group_mem [BUF_DEPTH];

    logic [PIXEL_W-1:0]    prev_eff;
    logic [MAPPED_W-1:0]   diff;
    logic [MAPPED_W-1:0]   mapped;
    logic                  big;
    logic [SUM_W-1:0]      sum;
    logic [CODE_W-1:0]     code_val;
    logic [15:0]           two_byte;
    logic [BUF_AW-1:0]     rd_addr;
    logic                  clear_group;

    assign prev_eff = row_start ? '0 : prev_reg;
    assign diff     = {pixel[PIXEL_W-1], pixel} - {prev_eff[PIXEL_W-1], prev_eff};
    assign mapped   = {diff[PIXEL_W-1:0], 1'b0} ^ {MAPPED_W{diff[MAPPED_W-1]}};

    assign big      = (m1_reg > DIFF_LIMIT) || (m2_reg > DIFF_LIMIT);
    assign sum      = m1_reg[SUM_W-1:0] + m2_reg[SUM_W-1:0];
    assign code_val = CODE_W'(m2_reg[SUM_W-1:0]) + CODE_W'(prod_reg[PROD_W-1:1]);
    assign two_byte = code_val[15:0] + TWO_BYTE_OFFSET;

    assign rd_addr     = cmd.emit_byte ? rd_idx_reg + BUF_AW'(1) : rd_idx_reg;
    assign clear_group = (cmd.emit_flag && status.group_empty)
                      || (cmd.emit_byte && status.drain_final);

    always_comb
    begin
        status.pair_done   = second_reg && !row_start;
        status.push_final  = (push_left_reg == PUSH_ONE);
        status.group_full  = (pair_idx_reg == LAST_PAIR);
        status.out_free    = !out_valid_reg || out_ready;
        status.group_empty = (cnt_reg == '0);
        status.drain_final = ({1'b0, rd_idx_reg} + COUNT_W'(1)) == cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            first_pix_reg <= '0;
            m1_reg        <= '0;
            second_reg    <= 1'b0;
            pair_idx_reg  <= '0;
            flag_reg      <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            push_left_reg <= PUSH_ONE;
        end
        else
        begin
            if (cmd.accept)
            begin
                prev_reg <= pixel;
                if (row_start)
                begin
                    pair_idx_reg <= '0;
                    flag_reg     <= '0;
                    cnt_reg      <= '0;
                end
                if (status.pair_done)
                begin
                    second_reg <= 1'b0;
                end
                else
                begin
                    first_pix_reg <= pixel;
                    m1_reg        <= mapped;
                    second_reg    <= 1'b1;
                end
            end

            if (cmd.code)
            begin
                if (big_reg || code_val >= TWO_BYTE_LIMIT)
                begin
                    push_left_reg <= PUSH_FOUR;
                    flag_reg      <= flag_reg | (FIRST_FLAG_BIT >> pair_idx_reg);
                end
                else if (code_val < ONE_BYTE_LIMIT)
                begin
                    push_left_reg <= PUSH_ONE;
                end
                else
                begin
                    push_left_reg <= PUSH_TWO;
                end
            end

            if (cmd.push)
            begin
                cnt_reg       <= cnt_reg + COUNT_W'(1);
                push_left_reg <= push_left_reg - 2'd1;
                if (status.push_final && !status.group_full)
                begin
                    pair_idx_reg <= pair_idx_reg + PAIR_IDX_W'(1);
                end
            end

            if (clear_group)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.emit_byte)
            begin
                rd_idx_reg <= rd_idx_reg + BUF_AW'(1);
            end

            if (clear_group)
            begin
                pair_idx_reg <= '0;
                flag_reg     <= '0;
                cnt_reg      <= '0;
            end

            if (cmd.emit_flag || cmd.emit_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.pair_done)
        begin
            pix2_reg <= pixel;
            m2_reg   <= mapped;
        end

        if (cmd.mult)
        begin
            big_reg  <= big;
            prod_reg <= PROD_W'(sum) * PROD_W'(sum + SUM_W'(1));
        end

        if (cmd.code)
        begin
            if (big_reg || code_val >= TWO_BYTE_LIMIT)
            begin
                push_bytes_reg <= {first_pix_reg, pix2_reg};
            end
            else if (code_val < ONE_BYTE_LIMIT)
            begin
                push_bytes_reg <= {code_val[7:0], 24'd0};
            end
            else
            begin
                push_bytes_reg <= {two_byte, 16'd0};
            end
        end
        else if (cmd.push)
        begin
            push_bytes_reg <= {push_bytes_reg[23:0], 8'd0};
        end

        if (cmd.push)
        begin
            group_mem[cnt_reg[BUF_AW-1:0]] <= push_bytes_reg[31:24];
        end

        rd_data_reg <= group_mem[rd_addr];

        if (cmd.emit_flag)
        begin
            out_byte_reg <= flag_reg;
            last_reg     <= status.group_empty;
        end
        else if (cmd.emit_byte)
        begin
            out_byte_reg <= rd_data_reg;
            last_reg     <= status.drain_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

### hw/rtl/pixel_pair_difference_encoder.sv
`default_nettype none
// A first pixel of a pair is stored; a second pixel passes S_MULT, S_CODE and S_PUSH, one
// push per coded byte (1, 2 or 4 writes into the group buffer). The buffer write port and
// the single output register set the rate: after the sixteenth pixel of a group the flag
// byte follows the last write, then one byte a cycle, whenever the output is free.
// rst_n clears the previous pixel, the pair and group state and the output valid at once.
// The group buffer needs no clearing; only entries written in the current group are read.

module pixel_pair_difference_encoder
    import pdenc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pdenc_pixel_if.sink   pixels,
    pdenc_byte_if.source  stream
);

    pdenc_cmd_t    cmd;
    pdenc_status_t status;

    pdenc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pdenc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel       (pixels.pixel),
        .row_start   (pixels.row_start),
        .out_ready   (stream.ready),
        .out_valid   (stream.valid),
        .out_byte    (stream.out_byte),
        .last_of_run (stream.last_of_run)
    );

endmodule

`default_nettype wire

### tb/sv/pdenc_stream_checker.sv
`default_nettype none

module pdenc_stream_checker
    import pdenc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pdenc_pixel_if    pixels,
    pdenc_byte_if     stream,
    output int        error_count,
    output int        bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAW_THRESHOLD  = 129;
    localparam int SHORT_CODE_END = 224;
    localparam int LONG_CODE_END  = 8416;
    localparam int LONG_CODE_BIAS = 57120;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } coded_byte_t;

    coded_byte_t                owed_q[$];
    logic [BYTE_W-1:0]          group_q[$];
    logic signed [PIXEL_W-1:0]  prev_px    = '0;
    logic signed [PIXEL_W-1:0]  held_px    = '0;
    logic [MAPPED_W-1:0]        held_diff  = '0;
    logic                       pair_open  = 1'b0;
    logic [PAIR_IDX_W-1:0]      pair_no    = '0;
    logic [BYTE_W-1:0]          raw_flags  = '0;
    int                         mismatches = 0;

    task automatic clear_group();
        pair_open = 1'b0;
        pair_no   = '0;
        raw_flags = '0;
        group_q.delete();
    endtask

    task automatic push_raw_pair(input logic [PIXEL_W-1:0] a, input logic [PIXEL_W-1:0] b);
        group_q.push_back(a[15:8]);
        group_q.push_back(a[7:0]);
        group_q.push_back(b[15:8]);
        group_q.push_back(b[7:0]);
        raw_flags[3'd7 - pair_no] = 1'b1;
    endtask

    task automatic encode_pixel(input logic signed [PIXEL_W-1:0] px, input logic rs);
        int                  cur_v;
        int                  prev_v;
        int                  d;
        int                  s;
        int                  c;
        logic [MAPPED_W-1:0] m;
        logic [15:0]         biased;
        if (rs)
        begin
            prev_px = '0;
            clear_group();
        end
        cur_v  = px;
        prev_v = prev_px;
        d      = cur_v - prev_v;
        m      = (d < 0) ? MAPPED_W'(-2 * d - 1) : MAPPED_W'(2 * d);
        prev_px = px;
        if (!pair_open)
        begin
            held_px   = px;
            held_diff = m;
            pair_open = 1'b1;
        end
        else
        begin
            pair_open = 1'b0;
            if (int'(held_diff) > RAW_THRESHOLD || int'(m) > RAW_THRESHOLD)
            begin
                push_raw_pair(held_px, px);
            end
            else
            begin
                s = int'(held_diff) + int'(m);
                c = int'(m) + (s * (s + 1)) / 2;
                if (c < SHORT_CODE_END)
                begin
                    group_q.push_back(BYTE_W'(c));
                end
                else if (c < LONG_CODE_END)
                begin
                    biased = 16'(c + LONG_CODE_BIAS);
                    group_q.push_back(biased[15:8]);
                    group_q.push_back(biased[7:0]);
                end
                else
                begin
                    push_raw_pair(held_px, px);
                end
            end
            if (pair_no == 3'd7)
            begin
                owed_q.push_back('{value: raw_flags, last: (group_q.size() == 0)});
                foreach (group_q[k])
                    owed_q.push_back('{value: group_q[k], last: (k == group_q.size() - 1)});
                clear_group();
            end
            else
            begin
                pair_no = pair_no + 3'd1;
            end
        end
    endtask

    task automatic check_byte(input logic [BYTE_W-1:0] got, input logic got_last);
        coded_byte_t want;
        if (owed_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("checker: unexpected byte %02h last %0b", got, got_last);
        end
        else
        begin
            want = owed_q.pop_front();
            if (got !== want.value || got_last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("checker: byte mismatch, expected %02h last %0b, got %02h last %0b",
                             want.value, want.last, got, got_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_px   = '0;
            held_px   = '0;
            held_diff = '0;
            clear_group();
            owed_q.delete();
            mismatches = 0;
            error_count <= 0;
            bytes_owed  <= 0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                check_byte(stream.out_byte, stream.last_of_run);
            if (pixels.valid && pixels.ready)
                encode_pixel(pixels.pixel, pixels.row_start);
            error_count <= mismatches;
            bytes_owed  <= owed_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_COUNT    = 330;
    localparam int STALL_PCT      = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int CALM_FROM      = 150;
    localparam int CALM_TO        = 230;

    // One group covering every code length and both raw triggers, then a stray
    // partial group that the next row start discards.
    localparam logic signed [15:0] OPENING [19] = '{
        0, 0, -4, -11, -8, -1, -51, -36, 13, -3,
        -68, -133, -68, -68, 32767, -32768, 21845, -1, 10922
    };

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               calm    = 1'b0;
    int                 sent    = 0;
    logic signed [15:0] last_px = '0;
    int                 error_count;
    int                 bytes_owed;

    pdenc_pixel_if pixels();
    pdenc_byte_if  stream();

    pixel_pair_difference_encoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .stream (stream)
    );

    pdenc_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .stream      (stream),
        .error_count (error_count),
        .bytes_owed  (bytes_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] next_pixel();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 16'($urandom_range(0, 65535));
        if (pick < 55)
            span = 8;
        else if (pick < 70)
            span = 20;
        else if (pick < 85)
            span = 40;
        else
            span = 66;
        return 16'(int'(last_px) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_pixel(input logic signed [15:0] px, input logic rs);
        while (!calm && $urandom_range(0, 99) < STALL_PCT)
        begin
            pixels.valid <= 1'b0;
            @(posedge clk);
        end
        pixels.valid     <= 1'b1;
        pixels.pixel     <= px;
        pixels.row_start <= rs;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        last_px = px;
        sent++;
        calm <= (sent >= CALM_FROM && sent < CALM_TO);
    endtask

    initial
    begin
        stream.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            stream.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pixels.valid && pixels.ready) || (stream.valid && stream.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        int row_len;
        pixels.valid     = 1'b0;
        pixels.pixel     = '0;
        pixels.row_start = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[k])
            send_pixel(OPENING[k], k == 0);

        // Mostly whole rows of complete groups; some rows of random length cut groups short.
        while (sent < PIXEL_COUNT)
        begin
            if ($urandom_range(0, 4) == 0)
                row_len = $urandom_range(1, 40);
            else
                row_len = 16 * $urandom_range(1, 3);
            for (int i = 0; i < row_len; i++)
            begin
                if (i == 0)
                    last_px = '0;
                send_pixel(next_pixel(), i == 0);
            end
        end
        pixels.valid <= 1'b0;

        do
            @(posedge clk);
        while (bytes_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && bytes_owed == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
